[rtl/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int POS_W   = 5;                        // position / index field width
  localparam int VALUE_W = 32;                       // value field width
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SCAN,
    S_PUT,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                        kind;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]           found_index;
    logic [POS_W-1:0]           list_length;
    status_e                    status;
  } rsp_t;

endpackage

[rtl/ple_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int DataW = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/positional_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values edited by 1-based position and queried by position or value.
// ----------------------------------------------------------------------------
// Flow: a rejected transaction goes straight to the result state; insert,
//   delete and locate walk the list one entry per cycle through the single
//   read port of the entry RAM (registered read), and get reads one entry.
// Throughput: one transaction at a time; busy stays high until the result
//   strobe has been shown, so the next one is taken in the cycle after it.
//   The receiver cannot stall the result.
// Reset: rst_ni clears the entry count and control; RAM contents are not
//   cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::req_t req_i,
  output logic          result_valid_o,
  output ple_pkg::rsp_t result_o
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ple_pkg::state_e  state_q, state_d;
  ple_pkg::op_e     op_q, op_d;
  ple_pkg::cnt_t    count_q, count_d;     // entries in the list
  ple_pkg::cnt_t    pos_q, pos_d;         // validated 1-based position
  ple_pkg::cnt_t    idx_q, idx_d;         // walk pointer
  ple_pkg::cnt_t    end_q, end_d;         // scan stops before this address
  ple_pkg::cnt_t    found_q, found_d;
  ple_pkg::data_t   val_q, val_d;
  ple_pkg::data_t   rv_q, rv_d;
  ple_pkg::status_e status_q, status_d;
  logic             pend_q, pend_d;       // a RAM read is in flight
  ple_pkg::addr_t   pend_addr_q, pend_addr_d;

  // RAM port signals
  logic             ram_we;
  ple_pkg::addr_t   ram_waddr;
  ple_pkg::data_t   ram_wdata;
  ple_pkg::addr_t   ram_raddr;
  ple_pkg::data_t   ram_rdata;

  // Request decode
  ple_pkg::cmp_t    req_pos;
  ple_pkg::cmp_t    cnt_ext;
  ple_pkg::cnt_t    pos_m1;
  ple_pkg::cnt_t    idx_m1;
  logic             issue_up;
  logic             issue_scan;
  logic             is_first;

  assign req_pos = (req_i.position == '0) ? ple_pkg::cmp_t'(1)
                                          : ple_pkg::cmp_t'(req_i.position);
  assign cnt_ext = ple_pkg::cmp_t'(count_q);
  assign pos_m1  = pos_q - ple_pkg::cnt_t'(1);
  assign idx_m1  = idx_q - ple_pkg::cnt_t'(1);

  // Insert walks dest k from count down to pos, reading k-1 and writing k in the
  // next cycle. Scans read idx up to end; delete writes each word back one
  // place lower. Reads and writes in flight never hit the same entry.
  assign issue_up   = (idx_q >= pos_q);
  assign issue_scan = (idx_q < end_q);
  assign is_first   = (ple_pkg::cnt_t'(pend_addr_q) == pos_m1);

  // --------------------------------------------------------------------------
  // Entry memory
  // --------------------------------------------------------------------------
  ple_ram #(
    .DataW (ple_pkg::DATA_WIDTH),
    .Depth (ple_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (start) begin
          case (req_i.kind)
            ple_pkg::OP_INSERT: begin
              if (req_pos > cnt_ext + ple_pkg::cmp_t'(1)) begin
                state_d = ple_pkg::S_RESP;
              end else if (cnt_ext >= ple_pkg::cmp_t'(ple_pkg::CAPACITY)) begin
                state_d = ple_pkg::S_RESP;
              end else begin
                state_d = ple_pkg::S_SHIFT_UP;
              end
            end
            ple_pkg::OP_DELETE, ple_pkg::OP_GET: begin
              if (req_pos > cnt_ext) begin
                state_d = ple_pkg::S_RESP;
              end else begin
                state_d = ple_pkg::S_SCAN;
              end
            end
            default: state_d = ple_pkg::S_SCAN;
          endcase
        end
      end
      ple_pkg::S_SHIFT_UP: begin
        if (!issue_up && !pend_q) begin
          state_d = ple_pkg::S_PUT;
        end
      end
      ple_pkg::S_SCAN: begin
        if (!issue_scan && !pend_q) begin
          state_d = ple_pkg::S_RESP;
        end
      end
      ple_pkg::S_PUT:  state_d = ple_pkg::S_RESP;
      ple_pkg::S_RESP: state_d = ple_pkg::S_IDLE;
      default:         state_d = ple_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    op_d        = op_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    end_d       = end_q;
    found_d     = found_q;
    val_d       = val_q;
    rv_d        = rv_q;
    status_d    = status_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[ple_pkg::ADDR_W-1:0];

    case (state_q)
      ple_pkg::S_IDLE: begin
        if (start) begin
          op_d     = req_i.kind;
          pos_d    = ple_pkg::cnt_t'(req_pos);
          val_d    = ple_pkg::data_t'(req_i.value);
          rv_d     = '0;
          found_d  = '0;
          status_d = ple_pkg::ST_OK;
          end_d    = count_q;
          case (req_i.kind)
            ple_pkg::OP_INSERT: begin
              idx_d = count_q;
              if (req_pos > cnt_ext + ple_pkg::cmp_t'(1)) begin
                status_d = ple_pkg::ST_RANGE;
              end else if (cnt_ext >= ple_pkg::cmp_t'(ple_pkg::CAPACITY)) begin
                status_d = ple_pkg::ST_FULL;
              end
            end
            ple_pkg::OP_DELETE: begin
              idx_d = ple_pkg::cnt_t'(req_pos - ple_pkg::cmp_t'(1));
              if (req_pos > cnt_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end
            end
            ple_pkg::OP_GET: begin
              idx_d = ple_pkg::cnt_t'(req_pos - ple_pkg::cmp_t'(1));
              end_d = ple_pkg::cnt_t'(req_pos);
              if (req_pos > cnt_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end
            end
            default: begin
              idx_d = '0;
            end
          endcase
        end
      end

      ple_pkg::S_SHIFT_UP: begin
        ram_raddr = idx_m1[ple_pkg::ADDR_W-1:0];
        if (issue_up) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q[ple_pkg::ADDR_W-1:0];
          idx_d       = idx_m1;
        end
        // land the word read last cycle one place higher
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
      end

      ple_pkg::S_SCAN: begin
        if (issue_scan) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q[ple_pkg::ADDR_W-1:0];
          idx_d       = idx_q + ple_pkg::cnt_t'(1);
        end
        if (pend_q) begin
          case (op_q)
            ple_pkg::OP_DELETE: begin
              if (is_first) begin
                rv_d = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_q - ple_pkg::addr_t'(1);
                ram_wdata = ram_rdata;
              end
            end
            ple_pkg::OP_GET: begin
              rv_d = ram_rdata;
            end
            ple_pkg::OP_LOCATE: begin
              if (found_q == '0 && ram_rdata == val_q) begin
                found_d = ple_pkg::cnt_t'(pend_addr_q) + ple_pkg::cnt_t'(1);
              end
            end
            default: ;
          endcase
        end
        if (!issue_scan && !pend_q && op_q == ple_pkg::OP_DELETE) begin
          count_d = count_q - ple_pkg::cnt_t'(1);
        end
      end

      ple_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1[ple_pkg::ADDR_W-1:0];
        ram_wdata = val_q;
        count_d   = count_q + ple_pkg::cnt_t'(1);
      end

      default: ;
    endcase
  end

  assign busy           = (state_q != ple_pkg::S_IDLE);
  assign result_valid_o = (state_q == ple_pkg::S_RESP);

  assign result_o.read_value  = ple_pkg::VALUE_W'(rv_q);
  assign result_o.found_index = ple_pkg::POS_W'(found_q);
  assign result_o.list_length = ple_pkg::POS_W'(count_q);
  assign result_o.status      = status_q;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    end_q       <= end_d;
    found_q     <= found_d;
    val_q       <= val_d;
    rv_q        <= rv_d;
    status_q    <= status_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

[rtl/ple_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input ple_pkg::req_t req_i,
  input logic          result_valid_o,
  input ple_pkg::rsp_t result_o
);

  // an accepted transaction makes the engine busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a transaction");

  // the result is shown while busy, and the engine frees up right after it
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy ##1 !busy)
    else $error("result strobe out of step with busy");

  // length never exceeds capacity
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.list_length <= ple_pkg::POS_W'(ple_pkg::CAPACITY))
    else $error("list length above capacity");

  // a rejected transaction returns no data
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ple_pkg::ST_OK |->
      result_o.read_value == '0 && result_o.found_index == '0)
    else $error("rejected transaction carries data");

  // length is unchanged by a rejected transaction
  a_reject_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(result_valid_o, 3) &&
      result_o.status != ple_pkg::ST_OK && $past(start && !busy, 1) |->
      result_o.list_length == $past(result_o.list_length, 3))
    else $error("rejected transaction changed the length");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
